FILE: design/cswa_pkg.sv
package cswa_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 2048;
    localparam int STORE_ROWS   = 6;
    localparam int SAMPLE_COUNT = 8;
    localparam int MIN_GEOM     = 8;
    localparam int GEOM_W       = 12;
    localparam int POS_W        = 11;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int CMP_W        = (COL_W + 1 > GEOM_W) ? COL_W + 1 : GEOM_W;
    localparam int SLOT_W       = $clog2(STORE_ROWS);
    localparam int WIN_IDX_W    = $clog2(SAMPLE_COUNT);
    localparam int ROW_MAX      = MAX_HEIGHT - 1;
    localparam int CENTER_LAG   = 2;
    localparam int HALF_WIN     = 3;
    localparam int EDGE_MARGIN  = 5;
    localparam int FIRST_POS    = HALF_WIN + CENTER_LAG;
    localparam int LAST_GAP     = EDGE_MARGIN - CENTER_LAG;
    localparam int AHEAD_ROW    = 4;
    localparam int REG_IDX_W    = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_MASK_ENABLE  = 2'd2
    } cfg_reg_t;

    typedef logic [7:0]        byte_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;

    typedef struct packed {
        byte_t mask;
        byte_t red;
        byte_t green;
        byte_t blue;
    } pix_t;

    function automatic slot_t slot_back(input slot_t s, input int k);
        int t;
        t = int'(s) - k;
        if (t < 0) begin
            t = t + STORE_ROWS;
        end
        return slot_t'(t);
    endfunction

    function automatic logic [WIN_IDX_W-1:0] first_max(input byte_t v [SAMPLE_COUNT]);
        byte_t                l1v [4];
        logic [WIN_IDX_W-1:0] l1i [4];
        byte_t                l2v [2];
        logic [WIN_IDX_W-1:0] l2i [2];
        for (int i = 0; i < 4; i++) begin
            if (v[2*i+1] > v[2*i]) begin
                l1v[i] = v[2*i+1];
                l1i[i] = WIN_IDX_W'(2*i+1);
            end else begin
                l1v[i] = v[2*i];
                l1i[i] = WIN_IDX_W'(2*i);
            end
        end
        for (int i = 0; i < 2; i++) begin
            if (l1v[2*i+1] > l1v[2*i]) begin
                l2v[i] = l1v[2*i+1];
                l2i[i] = l1i[2*i+1];
            end else begin
                l2v[i] = l1v[2*i];
                l2i[i] = l1i[2*i];
            end
        end
        return (l2v[1] > l2v[0]) ? l2i[1] : l2i[0];
    endfunction

endpackage

FILE: design/cswa_ram.sv
module cswa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/color_sparse_window_argmax_unit.sv
// Streams blurred BGR pixels with a mask byte in raster order, one word per clock unless stalled,
// and returns a one-hot code naming the first of eight fixed 7x7-window samples that holds
// the largest value (zero if masking is on and the centre mask byte is zero), for every
// interior centre (rows and columns 3 to size-5). The result for centre (y,x) comes from
// pixel (y+2,x+2) via the read stage and output register; border pixels give no word. The
// six most recent rows sit in six single-port RAMs of MAX_WIDTH x 32, one per row slot: each
// pixel writes its own slot and reads the other five, so one pixel enters per clock whenever
// the output register is free or being drained. A start_of_frame word restarts row and column count.
module color_sparse_window_argmax_unit
    import cswa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [GEOM_W-1:0]    cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_start_of_frame,
    input  logic [7:0]           s_blue,
    input  logic [7:0]           s_green,
    input  logic [7:0]           s_red,
    input  logic [7:0]           s_mask_value,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [POS_W-1:0]     m_center_row,
    output logic [POS_W-1:0]     m_center_col,
    output logic [7:0]           m_code,
    output logic                 m_last_in_frame
);

    logic [GEOM_W-1:0] frame_width_reg;
    logic [GEOM_W-1:0] frame_height_reg;
    logic              mask_enable_reg;

    col_t  col_reg, col_next, cur_col;
    row_t  row_reg, row_next, cur_row;
    slot_t slot_reg, slot_next, cur_slot;

    logic [CMP_W-1:0]  eff_w;
    logic [GEOM_W-1:0] eff_h;
    logic              accept, last_col, emit, last_px;

    logic              b_valid_reg, b_emit_reg, b_last_reg;
    row_t              b_row_reg;
    col_t              b_col_reg;
    slot_t             b_slot_reg;
    byte_t             b_green_reg;
    logic              b_adv, out_free;

    pix_t  ram_q [STORE_ROWS];
    pix_t  row_q [1:5];

    byte_t g5_tap_reg [1:5];
    byte_t r4_tap_reg [1:3];
    byte_t b3_tap_reg [1:1];
    byte_t g3_tap_reg [1:3];
    byte_t b2_tap_reg [1:5];
    byte_t m2_tap_reg [1:2];
    byte_t b1_tap_reg [1:1];

    byte_t                samp [SAMPLE_COUNT];
    logic [WIN_IDX_W-1:0] win;
    logic [7:0]           code;

    logic             m_valid_reg, m_last_reg;
    logic [POS_W-1:0] m_row_reg, m_col_reg;
    logic [7:0]       m_code_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= GEOM_W'(640);
            frame_height_reg <= GEOM_W'(480);
            mask_enable_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_MASK_ENABLE:  mask_enable_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (CMP_W'(frame_width_reg) < CMP_W'(MIN_GEOM)) begin
            eff_w = CMP_W'(MIN_GEOM);
        end else if (CMP_W'(frame_width_reg) > CMP_W'(MAX_WIDTH)) begin
            eff_w = CMP_W'(MAX_WIDTH);
        end else begin
            eff_w = CMP_W'(frame_width_reg);
        end
        if (frame_height_reg < GEOM_W'(MIN_GEOM)) begin
            eff_h = GEOM_W'(MIN_GEOM);
        end else if (frame_height_reg > GEOM_W'(MAX_HEIGHT)) begin
            eff_h = GEOM_W'(MAX_HEIGHT);
        end else begin
            eff_h = frame_height_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign b_adv    = b_valid_reg && (!b_emit_reg || out_free);
    assign s_ready  = !b_valid_reg || b_adv;
    assign accept   = s_valid && s_ready;

    always_comb begin
        if (s_start_of_frame) begin
            cur_col  = '0;
            cur_row  = '0;
            cur_slot = '0;
        end else begin
            cur_col  = (CMP_W'(col_reg) >= eff_w) ? '0 : col_reg;
            cur_row  = row_reg;
            cur_slot = slot_reg;
        end
        last_col = (CMP_W'(cur_col) + CMP_W'(1)) >= eff_w;
        emit = (cur_row >= ROW_W'(FIRST_POS)) && (cur_col >= COL_W'(FIRST_POS))
            && (GEOM_W'(cur_row) <= eff_h - GEOM_W'(LAST_GAP))
            && (CMP_W'(cur_col) <= eff_w - CMP_W'(LAST_GAP));
        last_px = (GEOM_W'(cur_row) == eff_h - GEOM_W'(LAST_GAP))
            && (CMP_W'(cur_col) == eff_w - CMP_W'(LAST_GAP));
        col_next  = last_col ? '0 : col_t'(cur_col + 1'b1);
        row_next  = cur_row;
        slot_next = cur_slot;
        if (last_col && cur_row != row_t'(ROW_MAX)) begin
            row_next  = row_t'(cur_row + 1'b1);
            slot_next = (cur_slot == slot_t'(STORE_ROWS - 1)) ? '0 : slot_t'(cur_slot + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    for (genvar i = 0; i < STORE_ROWS; i++) begin : g_slot
        logic wr_here, ahead_here;
        col_t addr;
        assign wr_here    = (cur_slot == slot_t'(i));
        assign ahead_here = (slot_back(cur_slot, AHEAD_ROW) == slot_t'(i));
        assign addr = (!wr_here && ahead_here) ? col_t'(cur_col + 1'b1) : cur_col;
        cswa_ram #(
            .WIDTH ($bits(pix_t)),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .aclk  (aclk),
            .en    (accept),
            .we    (accept && wr_here),
            .addr  (addr),
            .wdata ({s_mask_value, s_red, s_green, s_blue}),
            .rdata (ram_q[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (accept) begin
            b_valid_reg <= 1'b1;
        end else if (b_adv) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_emit_reg  <= emit;
            b_last_reg  <= last_px;
            b_row_reg   <= cur_row;
            b_col_reg   <= cur_col;
            b_slot_reg  <= cur_slot;
            b_green_reg <= s_green;
        end
    end

    always_comb begin
        for (int k = 1; k <= 5; k++) begin
            row_q[k] = ram_q[slot_back(b_slot_reg, k)];
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            g5_tap_reg[1] <= row_q[5].green;
            r4_tap_reg[1] <= row_q[4].red;
            b3_tap_reg[1] <= row_q[3].blue;
            g3_tap_reg[1] <= row_q[3].green;
            b2_tap_reg[1] <= row_q[2].blue;
            m2_tap_reg[1] <= row_q[2].mask;
            b1_tap_reg[1] <= row_q[1].blue;
            for (int j = 2; j <= 5; j++) begin
                g5_tap_reg[j] <= g5_tap_reg[j-1];
                b2_tap_reg[j] <= b2_tap_reg[j-1];
            end
            for (int j = 2; j <= 3; j++) begin
                r4_tap_reg[j] <= r4_tap_reg[j-1];
                g3_tap_reg[j] <= g3_tap_reg[j-1];
            end
            m2_tap_reg[2] <= m2_tap_reg[1];
        end
    end

    always_comb begin
        samp[0] = row_q[4].red;
        samp[1] = b2_tap_reg[5];
        samp[2] = b1_tap_reg[1];
        samp[3] = g5_tap_reg[5];
        samp[4] = r4_tap_reg[3];
        samp[5] = b3_tap_reg[1];
        samp[6] = b_green_reg;
        samp[7] = g3_tap_reg[3];
        win     = first_max(samp);
        if (mask_enable_reg && m2_tap_reg[2] == 8'd0) begin
            code = 8'd0;
        end else begin
            code = 8'(1 << win);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv && b_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv && b_emit_reg) begin
            m_row_reg  <= POS_W'(b_row_reg - ROW_W'(CENTER_LAG));
            m_col_reg  <= POS_W'(b_col_reg - COL_W'(CENTER_LAG));
            m_code_reg <= code;
            m_last_reg <= b_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_center_row    = m_row_reg;
    assign m_center_col    = m_col_reg;
    assign m_code          = m_code_reg;
    assign m_last_in_frame = m_last_reg;

    a_code_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot0(m_code_reg))
        else $error("result code has more than one bit set");

    a_zero_needs_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_code_reg == 8'd0) |-> mask_enable_reg)
        else $error("zero code with masking off");

    a_accept_fills_b: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> b_valid_reg)
        else $error("accepted word lost before read stage");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= slot_t'(STORE_ROWS - 1))
        else $error("row slot out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_code_reg) && m_valid_reg)
        else $error("pending result overwritten");

endmodule
